### rtl/ghrb_pkg.sv
// Package for the gamepad report builder: request types, op codes and constants.
// Used by every module in rtl/; depends on nothing else.
package ghrb_pkg;

    localparam int MAX_BUTTONS     = 32;
    localparam int MAX_AXES        = 8;
    localparam int NUM_HAT_FLAGS   = 4;

    localparam int BUTTON_COUNT_DEF   = 32;
    localparam int AXIS_COUNT_DEF     = 8;
    localparam int AXIS_BASE_CODE_DEF = 100;
    localparam int HAT_BASE_CODE_DEF  = 200;

    localparam logic [7:0] AXIS_CENTRE  = 8'd127;
    localparam logic [3:0] HAT_CENTRED  = 4'h0F;
    localparam logic [9:0] AXIS_IN_MAX  = 10'd1000;
    localparam int         AXIS_IN_W    = 10;

    // floor(v * 255 / 1000) == (v * 68451180) >> 28 exactly for 0 <= v <= 1000.
    localparam int          AXIS_SCALE_SHIFT = 28;
    localparam int          AXIS_PROD_W      = 37;
    localparam logic [26:0] AXIS_SCALE_MULT  = 27'd68451180;

    typedef enum logic [1:0] {
        OP_EVENT   = 2'd0,
        OP_SET_HAT = 2'd1,
        OP_REINIT  = 2'd2,
        OP_POLL    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         code;
        logic signed [15:0] value;
        logic               host_ready;
    } t_in_req;

    typedef struct packed {
        logic        send_report;
        logic [31:0] buttons;
        logic [63:0] axes_packed;
        logic [3:0]  hat;
        logic        pending;
    } t_out_req;

endpackage

### rtl/ghrb_axis_scale.sv
// Axis scaler: clamps a signed event value to 0..1000 and maps it to 0..255.
// Depends on ghrb_pkg for the scaling constants.
module ghrb_axis_scale
    import ghrb_pkg::*;
(
    input  logic signed [15:0] i_value,
    output logic [7:0]         o_scaled
);

    logic [AXIS_IN_W-1:0]   clamped;
    logic [AXIS_PROD_W-1:0] prod;

    always_comb begin
        if (i_value < 16'sd0) begin
            clamped = '0;
        end else if (i_value > $signed({6'd0, AXIS_IN_MAX})) begin
            clamped = AXIS_IN_MAX;
        end else begin
            clamped = i_value[AXIS_IN_W-1:0];
        end
    end

    // Multiply by a reciprocal of 1000 folded with the factor 255.
    assign prod     = AXIS_PROD_W'(clamped) * AXIS_SCALE_MULT;
    assign o_scaled = prod[AXIS_SCALE_SHIFT +: 8];

endmodule

### rtl/ghrb_hat_decode.sv
// Hat decoder: turns the up/down/left/right flags into an 8-way hat code.
// Depends on ghrb_pkg for the centred code.
module ghrb_hat_decode
    import ghrb_pkg::*;
(
    input  logic [NUM_HAT_FLAGS-1:0] i_flags,
    output logic [3:0]               o_hat
);

    localparam logic [3:0] HAT_N  = 4'd0;
    localparam logic [3:0] HAT_NE = 4'd1;
    localparam logic [3:0] HAT_E  = 4'd2;
    localparam logic [3:0] HAT_SE = 4'd3;
    localparam logic [3:0] HAT_S  = 4'd4;
    localparam logic [3:0] HAT_SW = 4'd5;
    localparam logic [3:0] HAT_W  = 4'd6;
    localparam logic [3:0] HAT_NW = 4'd7;

    logic up, dn, lf, rt;

    assign up = i_flags[0];
    assign dn = i_flags[1];
    assign lf = i_flags[2];
    assign rt = i_flags[3];

    // Opposing flags cancel; with both axes cancelled the hat is centred.
    always_comb begin
        if (up && !dn) begin
            if (rt && !lf) begin
                o_hat = HAT_NE;
            end else if (lf && !rt) begin
                o_hat = HAT_NW;
            end else begin
                o_hat = HAT_N;
            end
        end else if (dn && !up) begin
            if (rt && !lf) begin
                o_hat = HAT_SE;
            end else if (lf && !rt) begin
                o_hat = HAT_SW;
            end else begin
                o_hat = HAT_S;
            end
        end else if (rt && !lf) begin
            o_hat = HAT_E;
        end else if (lf && !rt) begin
            o_hat = HAT_W;
        end else begin
            o_hat = HAT_CENTRED;
        end
    end

endmodule

### rtl/gamepad_hid_report_builder.sv
// Gamepad report builder: a request accepted into the input register is applied to the
// report state as it moves on into the result register, which presents the result. Throughput
// is one request per cycle while the receiver takes each result, set by the single update path
// between the two registers that also writes the report state. A result waiting at the output
// still lets one request into an empty input register; after that the input stalls until the
// result is taken. Reset (i_rst_n low, synchronous) empties both registers, clears buttons,
// flags and the pending flag, sets every axis to 127 and the hat to centred.
module gamepad_hid_report_builder
    import ghrb_pkg::*;
#(
    parameter int BUTTON_COUNT   = BUTTON_COUNT_DEF,
    parameter int AXIS_COUNT     = AXIS_COUNT_DEF,
    parameter int AXIS_BASE_CODE = AXIS_BASE_CODE_DEF,
    parameter int HAT_BASE_CODE  = HAT_BASE_CODE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    // Input register. It refills in the same cycle that it hands its request on.
    logic    r_in_valid;
    t_in_req r_in_data;

    // Result register.
    logic     r_out_valid;
    t_out_req r_out_data;
    t_out_req n_out_data;
    logic     n_send;

    // Report state.
    logic [BUTTON_COUNT-1:0]  r_buttons, n_buttons;
    logic [7:0]               r_axes [AXIS_COUNT];
    logic [7:0]               n_axes [AXIS_COUNT];
    logic [3:0]               r_hat, n_hat;
    logic [NUM_HAT_FLAGS-1:0] r_flags, n_flags;
    logic                     r_changed, n_changed;

    logic advance;

    logic                     pressed;
    logic                     is_button;
    logic [AXIS_COUNT-1:0]    axis_match;
    logic [NUM_HAT_FLAGS-1:0] hat_match;
    logic                     is_axis;
    logic                     is_hat;
    logic [7:0]               axis_scaled;
    logic [3:0]               flag_hat;
    logic [3:0]               direct_hat;
    logic [7:0]               axes_full [MAX_AXES];

    // The request in the input register moves on whenever the result register is free
    // or is being emptied in this cycle; the report state is updated at the same edge.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Decode the event code. Buttons win over axes, and axes over hat flags, when the
    // ranges overlap.
    assign pressed   = r_in_data.value > 16'sd0;
    assign is_button = {1'b0, r_in_data.code} < 9'(BUTTON_COUNT);

    always_comb begin
        for (int i = 0; i < AXIS_COUNT; i++) begin
            axis_match[i] = r_in_data.code == 8'(AXIS_BASE_CODE + i);
        end
        for (int i = 0; i < NUM_HAT_FLAGS; i++) begin
            hat_match[i] = r_in_data.code == 8'(HAT_BASE_CODE + i);
        end
    end

    assign is_axis = !is_button && (|axis_match);
    assign is_hat  = !is_button && !is_axis && (|hat_match);

    ghrb_axis_scale u_axis_scale (
        .i_value  (r_in_data.value),
        .o_scaled (axis_scaled)
    );

    // Direction flags are worked out first so that the hat decoder sees the new set.
    always_comb begin
        n_flags = r_flags;
        if (r_in_data.op == OP_REINIT) begin
            n_flags = '0;
        end else if (r_in_data.op == OP_EVENT && is_hat) begin
            for (int i = 0; i < NUM_HAT_FLAGS; i++) begin
                if (hat_match[i]) begin
                    n_flags[i] = pressed;
                end
            end
        end
    end

    ghrb_hat_decode u_hat_decode (
        .i_flags (n_flags),
        .o_hat   (flag_hat)
    );

    // A direct hat request outside north..northwest centres the hat.
    assign direct_hat = (r_in_data.value < 16'sd0 || r_in_data.value > 16'sd7)
                        ? HAT_CENTRED : r_in_data.value[3:0];

    // Report update. An event or direct hat write of a value that is already held leaves the pending flag alone.
    always_comb begin
        n_buttons = r_buttons;
        n_axes    = r_axes;
        n_hat     = r_hat;
        n_changed = r_changed;
        n_send    = 1'b0;
        case (r_in_data.op)
            OP_EVENT: begin
                if (is_button) begin
                    for (int i = 0; i < BUTTON_COUNT; i++) begin
                        if (r_in_data.code == 8'(i)) begin
                            n_buttons[i] = pressed;
                        end
                    end
                    if (n_buttons != r_buttons) begin
                        n_changed = 1'b1;
                    end
                end else if (is_axis) begin
                    for (int i = 0; i < AXIS_COUNT; i++) begin
                        if (axis_match[i]) begin
                            n_axes[i] = axis_scaled;
                            if (axis_scaled != r_axes[i]) begin
                                n_changed = 1'b1;
                            end
                        end
                    end
                end else if (is_hat) begin
                    n_hat = flag_hat;
                    if (flag_hat != r_hat) begin
                        n_changed = 1'b1;
                    end
                end
            end
            OP_SET_HAT: begin
                n_hat = direct_hat;
                if (direct_hat != r_hat) begin
                    n_changed = 1'b1;
                end
            end
            OP_REINIT: begin
                n_buttons = '0;
                for (int i = 0; i < AXIS_COUNT; i++) begin
                    n_axes[i] = AXIS_CENTRE;
                end
                n_hat     = HAT_CENTRED;
                n_changed = 1'b1;
            end
            OP_POLL: begin
                if (r_changed && r_in_data.host_ready) begin
                    n_send    = 1'b1;
                    n_changed = 1'b0;
                end
            end
            default: begin
                n_changed = r_changed;
            end
        endcase
    end

    // Axes that are not built stay centred in the packed report.
    for (genvar g = 0; g < MAX_AXES; g++) begin : g_axes
        if (g < AXIS_COUNT) begin : g_used
            assign axes_full[g] = n_axes[g];
        end else begin : g_unused
            assign axes_full[g] = AXIS_CENTRE;
        end
    end

    always_comb begin
        n_out_data.send_report = n_send;
        n_out_data.buttons     = 32'(n_buttons);
        for (int i = 0; i < MAX_AXES; i++) begin
            n_out_data.axes_packed[8*i +: 8] = axes_full[i];
        end
        n_out_data.hat     = n_hat;
        n_out_data.pending = n_changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_buttons   <= '0;
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_axes[i] <= AXIS_CENTRE;
            end
            r_hat       <= HAT_CENTRED;
            r_flags     <= '0;
            r_changed   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_buttons <= n_buttons;
                r_axes    <= n_axes;
                r_hat     <= n_hat;
                r_flags   <= n_flags;
                r_changed <= n_changed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    a_send_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.send_report |-> !r_out_data.pending)
        else $error("report sent while pending is still shown");

    a_pending_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data.pending == r_changed)
        else $error("pending in result differs from the stored flag");

    a_hat_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data.hat == r_hat)
        else $error("hat in result differs from the stored hat");

    a_hat_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hat <= 4'd7 || r_hat == HAT_CENTRED)
        else $error("stored hat holds an unused code");

    a_advance_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("request moved on but no result is held");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for gamepad_hid_report_builder: directed and random requests,
// each report compared against a shadow copy of the gamepad report held here.
// Depends on rtl/ghrb_pkg.sv and rtl/gamepad_hid_report_builder.sv, and through it on the scaler and decoder.
module tb_top;
    import ghrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Event codes for the four hat direction flags, offset from the hat base code.
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    // Length of the receiver's hold-off when a long stall is requested.
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 1064;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_req o_out_data;

    // Shadow copy of the report, updated once per accepted request.
    logic [31:0] shadow_buttons;
    logic [7:0]  shadow_axes [MAX_AXES];
    logic [3:0]  shadow_hat;
    logic [3:0]  shadow_dirs;
    logic        shadow_pending;

    t_out_req expected_reports [$];

    int  error_count   = 0;
    int  requests_sent = 0;
    int  reports_seen  = 0;
    int  reports_sent  = 0;
    int  hold_requests = 0;
    bit  gaps_on       = 1'b1;
    int  burst_left    = 0;

    gamepad_hid_report_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow report model
    // ------------------------------------------------------------------

    // Puts the report back to its power-on contents. The pending flag is
    // left to the caller, since reset clears it but a reinitialise sets it.
    task automatic clear_shadow_report();
        shadow_buttons = '0;
        foreach (shadow_axes[i]) shadow_axes[i] = AXIS_CENTRE;
        shadow_hat  = HAT_CENTRED;
        shadow_dirs = '0;
    endtask

    // A hat write only counts as a change when the code actually differs.
    task automatic write_shadow_hat(input logic [3:0] hat_code);
        if (shadow_hat != hat_code) begin
            shadow_hat     = hat_code;
            shadow_pending = 1'b1;
        end
    endtask

    // Applies one request to the shadow report and returns the report the
    // block should answer with. Every op yields exactly one report.
    task automatic apply_request(input t_in_req req, output t_out_req rpt);
        int          code;
        int          val;
        int          clamped;
        logic [7:0]  scaled;
        logic [31:0] new_buttons;
        logic        up, dn, lf, rt;
        logic [3:0]  dir_hat;

        code = req.code;
        val  = $signed(req.value);
        rpt  = '0;

        case (req.op)
            OP_EVENT: begin
                // The button range wins over the axis range, and that over the hat.
                if (code < BUTTON_COUNT_DEF) begin
                    new_buttons = shadow_buttons;
                    new_buttons[code] = (val > 0);
                    if (new_buttons != shadow_buttons) begin
                        shadow_buttons = new_buttons;
                        shadow_pending = 1'b1;
                    end
                end else if (code >= AXIS_BASE_CODE_DEF &&
                             code < AXIS_BASE_CODE_DEF + AXIS_COUNT_DEF) begin
                    clamped = (val < 0) ? 0 : (val > AXIS_IN_MAX) ? AXIS_IN_MAX : val;
                    scaled  = 8'((clamped * 255) / AXIS_IN_MAX);
                    if (shadow_axes[code - AXIS_BASE_CODE_DEF] != scaled) begin
                        shadow_axes[code - AXIS_BASE_CODE_DEF] = scaled;
                        shadow_pending = 1'b1;
                    end
                end else if (code >= HAT_BASE_CODE_DEF &&
                             code < HAT_BASE_CODE_DEF + NUM_HAT_FLAGS) begin
                    shadow_dirs[code - HAT_BASE_CODE_DEF] = (val > 0);
                    up = shadow_dirs[DIR_UP];
                    dn = shadow_dirs[DIR_DOWN];
                    lf = shadow_dirs[DIR_LEFT];
                    rt = shadow_dirs[DIR_RIGHT];
                    // Opposing flags cancel; if both pairs cancel the hat is centred.
                    if (up && !dn)
                        dir_hat = (rt && !lf) ? 4'd1 : (lf && !rt) ? 4'd7 : 4'd0;
                    else if (dn && !up)
                        dir_hat = (rt && !lf) ? 4'd3 : (lf && !rt) ? 4'd5 : 4'd4;
                    else
                        dir_hat = (rt && !lf) ? 4'd2 : (lf && !rt) ? 4'd6 : HAT_CENTRED;
                    write_shadow_hat(dir_hat);
                end
                // Any other code is simply ignored.
            end
            OP_SET_HAT: begin
                // A direct hat write leaves the direction flags alone.
                write_shadow_hat((val < 0 || val > 7) ? HAT_CENTRED : val[3:0]);
            end
            OP_REINIT: begin
                clear_shadow_report();
                shadow_pending = 1'b1;
            end
            default: begin
                if (shadow_pending && req.host_ready) begin
                    rpt.send_report = 1'b1;
                    shadow_pending  = 1'b0;
                end
            end
        endcase

        rpt.buttons = shadow_buttons;
        foreach (shadow_axes[i]) rpt.axes_packed[i*8 +: 8] = shadow_axes[i];
        rpt.hat     = shadow_hat;
        rpt.pending = shadow_pending;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic t_in_req make_req(input t_op op, input int code, input int value,
                                         input bit ready);
        t_in_req req;
        req.op         = op;
        req.code       = code[7:0];
        req.value      = value[15:0];
        req.host_ready = ready;
        return req;
    endfunction

    // Offers one request and waits for it to be taken. The task is always
    // entered in the time step of the previous acceptance (or while idle),
    // so the first falling edge it sees is the one to drive on. When a burst
    // runs out, valid is dropped for a random gap before the next request.
    task automatic send_request(input t_in_req req);
        t_out_req rpt;
        int       gap;

        gap = 0;
        if (gaps_on && burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 6);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;

        do @(posedge i_clk); while (!o_in_ready);

        apply_request(req, rpt);
        expected_reports.push_back(rpt);
        requests_sent++;
        burst_left--;
    endtask

    // Drops valid once the last request has gone, then waits until every
    // report is back and lets the clock run on, so that stragglers are caught.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stretches of always ready, random ready and sparse ready,
    // overridden by a long hold-off whenever one is requested.
    // ------------------------------------------------------------------
    initial begin : receiver
        int seen_holds;
        int hold_left;
        int mode;
        int stretch;

        seen_holds  = 0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(4, 40);
            repeat (stretch) begin
                @(negedge i_clk);
                if (hold_requests != seen_holds) begin
                    seen_holds = hold_requests;
                    hold_left  = HOLD_CYCLES;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    i_out_ready <= 1'b0;
                end else begin
                    case (mode)
                        0, 1:    i_out_ready <= 1'b1;
                        2:       i_out_ready <= 1'($urandom_range(0, 1));
                        default: i_out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Report checker: every accepted report against the oldest expectation.
    // ------------------------------------------------------------------
    initial begin : report_checker
        t_out_req want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: %h", o_out_data);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    reports_seen++;
                    if (o_out_data.send_report)
                        reports_sent++;
                    if (o_out_data.send_report != want.send_report) begin
                        $error("send_report: expected %0d, got %0d",
                               want.send_report, o_out_data.send_report);
                        error_count++;
                    end
                    if (o_out_data.buttons != want.buttons) begin
                        $error("buttons: expected %h, got %h",
                               want.buttons, o_out_data.buttons);
                        error_count++;
                    end
                    if (o_out_data.axes_packed != want.axes_packed) begin
                        $error("axes_packed: expected %h, got %h",
                               want.axes_packed, o_out_data.axes_packed);
                        error_count++;
                    end
                    if (o_out_data.hat != want.hat) begin
                        $error("hat: expected %0d, got %0d", want.hat, o_out_data.hat);
                        error_count++;
                    end
                    if (o_out_data.pending != want.pending) begin
                        $error("pending: expected %0d, got %0d",
                               want.pending, o_out_data.pending);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lowest and highest button, a repeated press that changes nothing,
    // and a release with the most negative value.
    task automatic test_buttons();
        send_request(make_req(OP_EVENT, 0, 1, 1'b0));
        send_request(make_req(OP_EVENT, BUTTON_COUNT_DEF - 1, 32767, 1'b0));
        send_request(make_req(OP_EVENT, BUTTON_COUNT_DEF - 1, 5, 1'b1));
        send_request(make_req(OP_EVENT, 0, -32768, 1'b0));
        // Zero counts as released.
        send_request(make_req(OP_EVENT, 7, 0, 1'b1));
    endtask

    // Polls around a pending report: host busy, host ready, then nothing left.
    task automatic test_poll();
        send_request(make_req(OP_POLL, 0, 0, 1'b0));
        send_request(make_req(OP_POLL, 255, -1, 1'b1));
        send_request(make_req(OP_POLL, 0, 0, 1'b1));
    endtask

    // Both axis ends, clamping from either side, a value that scales to the
    // centre already held, and codes that fall into no range.
    task automatic test_axes();
        send_request(make_req(OP_EVENT, AXIS_BASE_CODE_DEF + 1, 500, 1'b0));
        send_request(make_req(OP_EVENT, AXIS_BASE_CODE_DEF, AXIS_IN_MAX, 1'b0));
        send_request(make_req(OP_EVENT, AXIS_BASE_CODE_DEF + AXIS_COUNT_DEF - 1, -32768,
                              1'b0));
        send_request(make_req(OP_EVENT, AXIS_BASE_CODE_DEF + 3, 32767, 1'b0));
        send_request(make_req(OP_EVENT, AXIS_BASE_CODE_DEF + AXIS_COUNT_DEF, 1000, 1'b0));
        send_request(make_req(OP_EVENT, 255, 1, 1'b0));
    endtask

    // Walks the direction flags through a diagonal, a left-right conflict
    // under up, all four held, and then releases up and left to end at south-east.
    task automatic test_hat_flags();
        send_request(make_req(OP_EVENT, HAT_BASE_CODE_DEF + DIR_UP, 1, 1'b0));
        send_request(make_req(OP_EVENT, HAT_BASE_CODE_DEF + DIR_RIGHT, 1, 1'b0));
        send_request(make_req(OP_EVENT, HAT_BASE_CODE_DEF + DIR_LEFT, 1, 1'b0));
        send_request(make_req(OP_EVENT, HAT_BASE_CODE_DEF + DIR_DOWN, 1, 1'b0));
        send_request(make_req(OP_EVENT, HAT_BASE_CODE_DEF + DIR_UP, 0, 1'b0));
        send_request(make_req(OP_EVENT, HAT_BASE_CODE_DEF + DIR_LEFT, -5, 1'b0));
    endtask

    // Direct hat codes at both legal ends and just outside either side.
    task automatic test_direct_hat();
        send_request(make_req(OP_SET_HAT, 0, 7, 1'b0));
        send_request(make_req(OP_SET_HAT, 0, 8, 1'b0));
        send_request(make_req(OP_SET_HAT, 0, 0, 1'b0));
        send_request(make_req(OP_SET_HAT, 0, -1, 1'b0));
    endtask

    // Reinitialise raises pending, as it does even on an untouched report; a send follows.
    task automatic test_reinit();
        send_request(make_req(OP_REINIT, 0, 0, 1'b0));
        send_request(make_req(OP_POLL, 0, 0, 1'b1));
    endtask

    // Mostly well-formed events, direct hat writes and reinitialises with random content,
    // polls with a random host, and a slice of fully random noise.
    task automatic test_random(input int count);
        t_in_req req;
        int      pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            req  = make_req(OP_EVENT, $urandom_range(0, 255), $urandom_range(0, 65535),
                            1'($urandom_range(0, 1)));
            if (pick < 30) begin
                req.code = 8'($urandom_range(0, BUTTON_COUNT_DEF - 1));
                if ($urandom_range(0, 3) != 0)
                    req.value = 16'($urandom_range(0, 1));
            end else if (pick < 50) begin
                req.code = 8'(AXIS_BASE_CODE_DEF + $urandom_range(0, AXIS_COUNT_DEF - 1));
                case ($urandom_range(0, 9))
                    0:       req.value = '0;
                    1:       req.value = 16'(AXIS_IN_MAX);
                    2, 3:    ;
                    default: req.value = 16'($urandom_range(0, AXIS_IN_MAX));
                endcase
            end else if (pick < 65) begin
                req.code = 8'(HAT_BASE_CODE_DEF + $urandom_range(0, NUM_HAT_FLAGS - 1));
                if ($urandom_range(0, 3) != 0)
                    req.value = 16'($urandom_range(0, 1));
            end else if (pick < 72) begin
                req.op = OP_SET_HAT;
                if ($urandom_range(0, 3) != 0)
                    req.value = 16'(int'($urandom_range(0, 10)) - 1);
            end else if (pick < 75) begin
                req.op = OP_REINIT;
            end else if (pick < 90) begin
                req.op = OP_POLL;
            end else begin
                req.op = t_op'($urandom_range(0, 3));
            end
            send_request(req);
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming with
    // no gaps, so both registers fill and the input must stall.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_requests++;
        test_random(60);
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        clear_shadow_report();
        shadow_pending = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_buttons();
        test_poll();
        test_axes();
        test_hat_flags();
        test_direct_hat();
        test_reinit();
        test_random(RANDOM_ITEMS / 2);
        test_backpressure();
        test_random(RANDOM_ITEMS / 2);
        wait_drained();

        $display("Covered %0d requests (buttons, axes, hat flags, direct hat, reinit, poll).",
                 requests_sent);
        $display("Checked %0d reports, %0d of them sent to the host, with %0d mismatches.",
                 reports_seen, reports_sent, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog well beyond the slowest legitimate run.
    initial begin : watchdog
        #3_000_000;
        $display("Timed out with %0d reports still outstanding.", expected_reports.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/ghrb_pkg.sv
rtl/ghrb_axis_scale.sv
rtl/ghrb_hat_decode.sv
rtl/gamepad_hid_report_builder.sv
test/tb_top.sv
